/* sv/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the framed command controller
// Holds the command codes, frame characters and the descriptor that the
// front end hands to the transmit sequencer through the queue.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam logic [1:0] REQ_RX_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_SAMPLE  = 2'd2;

    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_O = 8'h4F;
    localparam logic [7:0] CHAR_M = 8'h4D;

    localparam logic [7:0] CMD_SET0   = 8'hA0;
    localparam logic [7:0] CMD_SET1   = 8'hA1;
    localparam logic [7:0] CMD_SET2   = 8'hA2;
    localparam logic [7:0] CMD_TOGGLE = 8'hA3;
    localparam logic [7:0] CMD_START  = 8'hA4;
    localparam logic [7:0] CMD_STOP   = 8'hA5;
    localparam logic [7:0] CMD_TEMP   = 8'hA8;
    localparam logic [7:0] CMD_RD_STA = 8'hAA;
    localparam logic [7:0] CMD_RD_STO = 8'hAB;
    localparam logic [7:0] CMD_STATUS = 8'hAE;

    localparam logic [7:0] STAT_CTRL  = 8'h80;
    localparam logic [7:0] STAT_START = 8'h40;
    localparam logic [7:0] STAT_STOP  = 8'h20;
    localparam logic [7:0] STAT_TAIL  = 8'hFF;

    localparam int          TIME_W     = 14;
    localparam logic [15:0] TPS_RESET  = 16'd10000;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // floor(x/60) ~ (x*1092) >> 16, low by at most one for 14-bit x
    localparam logic [10:0] DIV60_RECIP = 11'd1092;
    localparam int          DIV60_SHIFT = 16;
    localparam logic [5:0]  SIXTY       = 6'd60;

    localparam logic [2:0]  BEAT_LAST   = 3'd5;

    // one entry per accepted transaction
    typedef struct packed {
        logic              reply;      // six-byte frame follows
        logic [7:0]        code;
        logic              use_div;    // data bytes come from time_val
        logic [7:0]        data1;
        logic [7:0]        data2;
        logic [TIME_W-1:0] time_val;
        logic              control_on;
        logic [7:0]        setpoint;
    } desc_t;

endpackage

/* sv/fcc_front.sv */
// ----------------------------------------------------------------------------
// fcc_front: receive parser, command decode and timers
// Updates all controller state but ticks_per_second on each accepted
// transaction and emits one descriptor per transaction.
// ----------------------------------------------------------------------------
module fcc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               accept,
    input  logic [1:0]         req_type,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         adc_sample,
    output fcc_pkg::desc_t     desc
);
    import fcc_pkg::*;

    typedef enum logic [5:0] {
        RX_IDLE  = 6'b000001,
        RX_GOT_C = 6'b000010,
        RX_GOT_O = 6'b000100,
        RX_PAY0  = 6'b001000,
        RX_PAY1  = 6'b010000,
        RX_PAY2  = 6'b100000
    } rx_state_t;

    rx_state_t          rx_state_reg, rx_state_next;
    logic [7:0]         pay0_reg, pay1_reg;
    logic [7:0]         setpoint_reg, setpoint_next;
    logic               control_reg, control_next;
    logic               start_armed_reg, start_armed_next;
    logic               stop_armed_reg, stop_armed_next;
    logic [TIME_W-1:0]  start_left_reg, start_left_next;
    logic [TIME_W-1:0]  stop_left_reg, stop_left_next;
    logic [6:0]         temp_reg, temp_next;
    logic [15:0]        tick_reg, tick_next;
    logic [15:0]        tps_reg;

    logic [15:0]        tick_inc;
    logic [14:0]        smp_x100;
    logic [14:0]        temp_sum;
    logic [14:0]        delay_sum;
    logic [TIME_W-1:0]  delay_val;
    logic [7:0]         status_byte;

    assign tick_inc    = tick_reg + 16'd1;
    assign smp_x100    = {1'b0, adc_sample, 6'b0} + {2'b0, adc_sample, 5'b0}
                       + {5'b0, adc_sample, 2'b0};
    // floor(y/255) for y = sample*100, at most 25500: (y + (y>>8) + 1) >> 8
    assign temp_sum    = smp_x100 + {8'b0, smp_x100[14:8]} + 15'd1;
    // minutes*60 + seconds
    assign delay_sum   = {1'b0, pay1_reg, 6'b0} - {5'b0, pay1_reg, 2'b0}
                       + {7'b0, rx_byte};
    assign delay_val   = delay_sum[TIME_W-1:0];
    assign status_byte = (control_reg ? STAT_CTRL : 8'h00)
                       | (start_armed_reg ? STAT_START : 8'h00)
                       | (stop_armed_reg ? STAT_STOP : 8'h00);

    always_comb
    begin
        rx_state_next    = rx_state_reg;
        setpoint_next    = setpoint_reg;
        control_next     = control_reg;
        start_armed_next = start_armed_reg;
        stop_armed_next  = stop_armed_reg;
        start_left_next  = start_left_reg;
        stop_left_next   = stop_left_reg;
        temp_next        = temp_reg;
        tick_next        = tick_reg;
        desc.reply       = 1'b0;
        desc.code        = rx_byte;
        desc.use_div     = 1'b0;
        desc.data1       = 8'h00;
        desc.data2       = 8'h00;
        desc.time_val    = start_left_reg;

        if (req_type == REQ_RX_BYTE)
        begin
            unique case (rx_state_reg)
                RX_IDLE:  rx_state_next = (rx_byte == CHAR_C) ? RX_GOT_C : RX_IDLE;
                RX_GOT_C: rx_state_next = (rx_byte == CHAR_O) ? RX_GOT_O : RX_IDLE;
                RX_GOT_O: rx_state_next = (rx_byte == CHAR_M) ? RX_PAY0 : RX_IDLE;
                RX_PAY0:  rx_state_next = RX_PAY1;
                RX_PAY1:  rx_state_next = RX_PAY2;
                RX_PAY2:
                begin
                    rx_state_next = RX_IDLE;
                    desc.code     = pay0_reg;
                    unique case (pay0_reg)
                        CMD_SET0, CMD_SET1, CMD_SET2: setpoint_next = pay1_reg;
                        CMD_TOGGLE: control_next = ~control_reg;
                        CMD_START:
                        begin
                            start_left_next  = delay_val;
                            start_armed_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            stop_left_next  = delay_val;
                            stop_armed_next = 1'b1;
                        end
                        CMD_TEMP:
                        begin
                            desc.reply = 1'b1;
                            desc.data1 = {1'b0, temp_reg};
                        end
                        CMD_RD_STA:
                        begin
                            desc.reply   = 1'b1;
                            desc.use_div = 1'b1;
                        end
                        CMD_RD_STO:
                        begin
                            desc.reply    = 1'b1;
                            desc.use_div  = 1'b1;
                            desc.time_val = stop_left_reg;
                        end
                        CMD_STATUS:
                        begin
                            desc.reply = 1'b1;
                            desc.data1 = status_byte;
                            desc.data2 = STAT_TAIL;
                        end
                        default: ;
                    endcase
                end
                default:  rx_state_next = RX_IDLE;
            endcase
        end
        else if (req_type == REQ_TICK)
        begin
            tick_next = tick_inc;
            if (tick_inc >= tps_reg)
            begin
                tick_next = 16'd0;
                if (start_armed_reg)
                begin
                    if (start_left_reg <= TIME_W'(1))
                    begin
                        start_left_next  = '0;
                        start_armed_next = 1'b0;
                        control_next     = 1'b1;
                    end
                    else
                    begin
                        start_left_next = start_left_reg - TIME_W'(1);
                    end
                end
                // stop applied after start, so a shared second ends off
                if (stop_armed_reg)
                begin
                    if (stop_left_reg <= TIME_W'(1))
                    begin
                        stop_left_next  = '0;
                        stop_armed_next = 1'b0;
                        control_next    = 1'b0;
                    end
                    else
                    begin
                        stop_left_next = stop_left_reg - TIME_W'(1);
                    end
                end
            end
        end
        else if (req_type == REQ_SAMPLE)
        begin
            temp_next = temp_sum[14:8];
        end

        desc.control_on = control_next;
        desc.setpoint   = setpoint_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state_reg    <= RX_IDLE;
            setpoint_reg    <= '0;
            control_reg     <= 1'b0;
            start_armed_reg <= 1'b0;
            stop_armed_reg  <= 1'b0;
            start_left_reg  <= '0;
            stop_left_reg   <= '0;
            temp_reg        <= '0;
            tick_reg        <= '0;
            tps_reg         <= TPS_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tps_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                rx_state_reg    <= rx_state_next;
                setpoint_reg    <= setpoint_next;
                control_reg     <= control_next;
                start_armed_reg <= start_armed_next;
                stop_armed_reg  <= stop_armed_next;
                start_left_reg  <= start_left_next;
                stop_left_reg   <= stop_left_next;
                temp_reg        <= temp_next;
                tick_reg        <= tick_next;
            end
        end
    end

    // payload bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_RX_BYTE)
        begin
            if (rx_state_reg == RX_PAY0)
            begin
                pay0_reg <= rx_byte;
            end
            if (rx_state_reg == RX_PAY1)
            begin
                pay1_reg <= rx_byte;
            end
        end
    end

endmodule

/* sv/fcc_queue.sv */
// ----------------------------------------------------------------------------
// fcc_queue: descriptor queue between front end and transmit sequencer
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fcc_queue #(
    parameter int DEPTH = fcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fcc_pkg::desc_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output fcc_pkg::desc_t  pop_data
);
    import fcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    desc_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

/* sv/fcc_back.sv */
// ----------------------------------------------------------------------------
// fcc_back: transmit sequencer
// Pops descriptors and drives one status result or a six-byte frame
// through the output register; splits delay values into minutes/seconds.
// ----------------------------------------------------------------------------
module fcc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  fcc_pkg::desc_t  q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic            tx_last,
    output logic            control_on,
    output logic [7:0]      setpoint
);
    import fcc_pkg::*;

    localparam int PROD_W = TIME_W + 11;

    desc_t              cur_reg;
    logic               busy_reg;
    logic [2:0]         beat_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [7:0]         min_reg;
    logic [5:0]         sec_reg;

    logic               out_valid_reg;
    logic               tx_valid_reg, tx_last_reg, control_reg;
    logic [7:0]         tx_byte_reg, setpoint_reg;

    logic               can_load, emit, last_beat;
    logic [7:0]         beat_byte;
    logic [8:0]         q_est;
    logic [14:0]        q_x60, rem_est;

    assign can_load  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && can_load;
    assign last_beat = !cur_reg.reply || (beat_reg == BEAT_LAST);
    assign q_pop     = q_not_empty && (!busy_reg || (emit && last_beat));

    // divide by 60: reciprocal estimate, then one correction step
    assign q_est   = prod_reg[DIV60_SHIFT +: 9];
    assign q_x60   = {q_est, 6'b0} - {4'b0, q_est, 2'b0};
    assign rem_est = {1'b0, cur_reg.time_val} - q_x60;

    always_comb
    begin
        unique case (beat_reg)
            3'd0:    beat_byte = CHAR_C;
            3'd1:    beat_byte = CHAR_O;
            3'd2:    beat_byte = CHAR_M;
            3'd3:    beat_byte = cur_reg.code;
            3'd4:    beat_byte = cur_reg.use_div ? min_reg : cur_reg.data1;
            default: beat_byte = cur_reg.use_div ? {2'b0, sec_reg} : cur_reg.data2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= cur_reg.time_val * DIV60_RECIP;
        if (rem_est >= {9'b0, SIXTY})
        begin
            min_reg <= 8'(q_est + 9'd1);
            sec_reg <= 6'(rem_est - {9'b0, SIXTY});
        end
        else
        begin
            min_reg <= q_est[7:0];
            sec_reg <= rem_est[5:0];
        end
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            tx_valid_reg <= cur_reg.reply;
            tx_byte_reg  <= cur_reg.reply ? beat_byte : 8'h00;
            tx_last_reg  <= last_beat;
            control_reg  <= cur_reg.control_on;
            setpoint_reg <= cur_reg.setpoint;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                beat_reg <= '0;
            end
            else if (emit && last_beat)
            begin
                busy_reg <= 1'b0;
                beat_reg <= '0;
            end
            else if (emit)
            begin
                beat_reg <= beat_reg + 3'd1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_last    = tx_last_reg;
    assign control_on = control_reg;
    assign setpoint   = setpoint_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (beat_reg <= BEAT_LAST))
        else $error("beat index past end of frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tx_last_reg) |-> (busy_reg && cur_reg.reply))
        else $error("frame beat shown with no frame in progress");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tx_valid_reg) |-> tx_last_reg)
        else $error("status result not marked last");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !last_beat && !q_pop) |=> busy_reg)
        else $error("frame dropped before its last beat");

endmodule

/* sv/framed_command_controller.sv */
// ----------------------------------------------------------------------------
// framed_command_controller: serial command parser with delayed start/stop
// Front end parses transactions and updates state; a queue feeds the
// transmit sequencer, which sends status results or six-byte reply frames.
// ----------------------------------------------------------------------------
// Path: the first result of a transaction goes from the queue through the
//   sequencer's descriptor register into the output register.
// Throughput: one transaction per cycle when it yields a status result; a
//   reply frame holds the output port for its six bytes, one byte per cycle,
//   while out_ready is high; set by the sequencer and the single output register.
// Reset: parser idle, setpoint, control, delays, temperature and tick
//   count cleared, ticks_per_second back to 10000; queue and output empty.
//   The payload bytes hold no reset value.
module framed_command_controller #(
    parameter int QUEUE_DEPTH = fcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: ticks_per_second
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  adc_sample,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        control_on,
    output logic [7:0]  setpoint
);
    import fcc_pkg::*;

    desc_t  front_desc;
    desc_t  q_data;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    logic   accept;

    // The front end never waits on the sequencer directly: it only stops
    // when the descriptor queue is full.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Parser, command decode, prescaler and delay countdown. Every state
    // change but the ticks_per_second write happens at the accepting edge;
    // the descriptor snapshots control and setpoint after the transaction.
    fcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .adc_sample  (adc_sample),
        .desc        (front_desc)
    );

    // Decouples the two sides so a six-byte reply does not stall parsing
    // of the transactions behind it until the queue fills.
    fcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // Output sequencer: one beat per cycle into the output register while
    // out_ready is high. Delay readbacks are split into minutes and seconds
    // while the header bytes go out.
    fcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .tx_last     (tx_last),
        .control_on  (control_on),
        .setpoint    (setpoint)
    );

endmodule
